// ===== hdl/tlcg_pkg.sv =====
// ============================================================================
// tlcg_pkg
// Shared types and constants of the three-generator shuffle random source:
// generator moduli, multipliers, increments, reciprocals and the sequencer
// state encoding.
// ============================================================================
package tlcg_pkg;

  // Number of generator lanes and their positions.
  localparam int LANES      = 3;
  localparam int LANE_ONE   = 0;
  localparam int LANE_TWO   = 1;
  localparam int LANE_THREE = 2;

  // Widths: generator value, pre-reduction value, estimated quotient,
  // remainder before the final correction, seed and table word.
  localparam int GW     = 18;
  localparam int PW     = 32;
  localparam int QW     = 16;
  localparam int RW     = 19;
  localparam int SEED_W = 31;
  localparam int NW     = 36;

  typedef logic [GW-1:0] gen_t;
  typedef logic [LANES-1:0][GW-1:0] gen_vec_t;

  // Generator constants, one entry per lane.
  localparam gen_t        LCG_M [LANES] = '{18'd259200, 18'd134456, 18'd243000};
  localparam logic [12:0] LCG_A [LANES] = '{13'd7141, 13'd8121, 13'd4561};
  localparam logic [15:0] LCG_C [LANES] = '{16'd54773, 16'd28411, 16'd51349};

  // floor(2^32 / M): the quotient estimate from it is low by at most one.
  localparam logic [QW-1:0] LCG_RECIP [LANES] = '{
    16'((64'd1 << PW) / 64'd259200),
    16'((64'd1 << PW) / 64'd134456),
    16'((64'd1 << PW) / 64'd243000)
  };

  // Request to the modulo step unit.
  typedef struct packed {
    logic valid;
    logic seed_mode;
  } step_req_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_SEED_W,
    ST_PRE_A,
    ST_PRE_A_W,
    ST_PRE_B,
    ST_PRE_B_W,
    ST_FILL,
    ST_FILL_W,
    ST_STEP,
    ST_STEP_W,
    ST_SLOT_W,
    ST_WB,
    ST_OUT
  } state_t;

endpackage

// ===== hdl/three_lcg_shuffle_random.sv =====
// ============================================================================
// three_lcg_shuffle_random
// Uniform random source from three linear congruential generators and a
// shuffle table. Each result is the numerator of a fraction over M1*M2.
// ============================================================================
//
//   Channel  Dir  Signals                    Contents
//   -------  ---  -------------------------  ---------------------------------
//   s        in   s_tvalid/s_tready/s_tdata  seed; s_tuser = reseed request
//   m        out  m_tvalid/m_tready/m_tdata  random numerator
//
// A primed draw raises m_tvalid once its input word is accepted and has passed
// the three-stage step unit, the three-stage slot divider and the table read
// in series. The next input word is taken only when the sequencer is back in
// idle, so draws do not overlap. Priming (reseed, or the first draw after reset)
// adds one step unit pass for each table entry plus three for the seed.
// Reset is synchronous; the table holds no reset value and is filled by
// priming before any read. A finished word waits in the output register
// while the next input word is accepted; if that register is still full when
// the following result is ready, the input stalls until it drains.
//
module three_lcg_shuffle_random #(
  parameter int TABLE_SIZE = 97
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [30:0] seed, [31] zero
  input  logic        s_tuser,   // [0] action (1 = reseed, then draw)
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [35:0] random_numerator, [39:36] zero
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam logic [IW-1:0] LAST = IW'(TABLE_SIZE - 1);

  tlcg_pkg::state_t state;
  tlcg_pkg::state_t state_next;

  tlcg_pkg::gen_t gen_one;
  tlcg_pkg::gen_t gen_two;
  tlcg_pkg::gen_t gen_three;
  logic           primed;
  logic [IW-1:0]  fill_idx;
  logic [tlcg_pkg::SEED_W-1:0] seed;

  tlcg_pkg::step_req_t step_req;
  tlcg_pkg::gen_vec_t  step_x;
  tlcg_pkg::gen_vec_t  step_r;
  logic                step_valid;

  logic            slot_start;
  logic            slot_valid;
  logic [IW-1:0]   slot;

  logic                     rd_en;
  logic                     wr_en;
  logic                     wr_from_gens;
  logic [IW-1:0]            wr_addr;
  logic [tlcg_pkg::NW-1:0]  wr_data;
  logic [tlcg_pkg::NW-1:0]  rd_data;
  tlcg_pkg::gen_t           cmb_a;
  tlcg_pkg::gen_t           cmb_b;

  logic out_free;
  logic out_load;
  logic in_accept;
  tlcg_pkg::gen_t r_one;

  // Datapath units.
  tlcg_step u_step (
    .clk       (clk),
    .rst       (rst),
    .req       (step_req),
    .x         (step_x),
    .seed      (seed),
    .out_valid (step_valid),
    .r         (step_r)
  );

  tlcg_slot #(.TABLE_SIZE(TABLE_SIZE)) u_slot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (slot_start),
    .g3        (step_r[tlcg_pkg::LANE_THREE]),
    .out_valid (slot_valid),
    .slot      (slot)
  );

  tlcg_table #(.TABLE_SIZE(TABLE_SIZE)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (slot),
    .rd_data (rd_data)
  );

  assign step_x[tlcg_pkg::LANE_ONE]   = gen_one;
  assign step_x[tlcg_pkg::LANE_TWO]   = gen_two;
  assign step_x[tlcg_pkg::LANE_THREE] = gen_three;
  assign r_one = step_r[tlcg_pkg::LANE_ONE];

  // Table word: gen_one*M2 + gen_two, from fresh step results while filling.
  assign cmb_a   = wr_from_gens ? gen_one : r_one;
  assign cmb_b   = wr_from_gens ? gen_two : step_r[tlcg_pkg::LANE_TWO];
  assign wr_data = {18'b0, cmb_a} * {18'b0, tlcg_pkg::LCG_M[tlcg_pkg::LANE_TWO]}
                 + {18'b0, cmb_b};

  assign out_free  = !m_tvalid || m_tready;
  assign in_accept = s_tvalid && s_tready;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      tlcg_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tuser || !primed) ? tlcg_pkg::ST_SEED : tlcg_pkg::ST_STEP;
        end
      end
      tlcg_pkg::ST_SEED:   state_next = tlcg_pkg::ST_SEED_W;
      tlcg_pkg::ST_SEED_W: begin
        if (step_valid) state_next = tlcg_pkg::ST_PRE_A;
      end
      tlcg_pkg::ST_PRE_A:   state_next = tlcg_pkg::ST_PRE_A_W;
      tlcg_pkg::ST_PRE_A_W: begin
        if (step_valid) state_next = tlcg_pkg::ST_PRE_B;
      end
      tlcg_pkg::ST_PRE_B:   state_next = tlcg_pkg::ST_PRE_B_W;
      tlcg_pkg::ST_PRE_B_W: begin
        if (step_valid) state_next = tlcg_pkg::ST_FILL;
      end
      tlcg_pkg::ST_FILL:   state_next = tlcg_pkg::ST_FILL_W;
      tlcg_pkg::ST_FILL_W: begin
        if (step_valid) begin
          state_next = (fill_idx == LAST) ? tlcg_pkg::ST_STEP : tlcg_pkg::ST_FILL;
        end
      end
      tlcg_pkg::ST_STEP:   state_next = tlcg_pkg::ST_STEP_W;
      tlcg_pkg::ST_STEP_W: begin
        if (step_valid) state_next = tlcg_pkg::ST_SLOT_W;
      end
      tlcg_pkg::ST_SLOT_W: begin
        if (slot_valid) state_next = tlcg_pkg::ST_WB;
      end
      tlcg_pkg::ST_WB: begin
        state_next = out_free ? tlcg_pkg::ST_IDLE : tlcg_pkg::ST_OUT;
      end
      tlcg_pkg::ST_OUT: begin
        if (out_free) state_next = tlcg_pkg::ST_IDLE;
      end
      default: state_next = tlcg_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    s_tready           = (state == tlcg_pkg::ST_IDLE);
    step_req.valid     = state inside {tlcg_pkg::ST_SEED, tlcg_pkg::ST_PRE_A,
                                       tlcg_pkg::ST_PRE_B, tlcg_pkg::ST_FILL,
                                       tlcg_pkg::ST_STEP};
    step_req.seed_mode = (state == tlcg_pkg::ST_SEED);
    slot_start         = (state == tlcg_pkg::ST_STEP_W) && step_valid;
    rd_en              = (state == tlcg_pkg::ST_SLOT_W) && slot_valid;
    wr_from_gens       = (state == tlcg_pkg::ST_WB);
    wr_en              = ((state == tlcg_pkg::ST_FILL_W) && step_valid)
                         || (state == tlcg_pkg::ST_WB);
    wr_addr            = wr_from_gens ? slot : fill_idx;
    out_load           = (state inside {tlcg_pkg::ST_WB, tlcg_pkg::ST_OUT}) && out_free;
  end

  // State register and generator updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tlcg_pkg::ST_IDLE;
      gen_one   <= '0;
      gen_two   <= '0;
      gen_three <= '0;
      primed    <= 1'b0;
      fill_idx  <= '0;
    end else begin
      state <= state_next;
      if (step_valid) begin
        case (state)
          tlcg_pkg::ST_SEED_W: begin
            gen_one <= r_one;
          end
          tlcg_pkg::ST_PRE_A_W: begin
            gen_one <= r_one;
            // Generator one stays below 2*M2, so one subtract reduces it.
            if (r_one >= tlcg_pkg::LCG_M[tlcg_pkg::LANE_TWO]) begin
              gen_two <= r_one - tlcg_pkg::LCG_M[tlcg_pkg::LANE_TWO];
            end else begin
              gen_two <= r_one;
            end
          end
          tlcg_pkg::ST_PRE_B_W: begin
            gen_one  <= r_one;
            fill_idx <= '0;
            if (r_one >= tlcg_pkg::LCG_M[tlcg_pkg::LANE_THREE]) begin
              gen_three <= r_one - tlcg_pkg::LCG_M[tlcg_pkg::LANE_THREE];
            end else begin
              gen_three <= r_one;
            end
          end
          tlcg_pkg::ST_FILL_W: begin
            gen_one <= r_one;
            gen_two <= step_r[tlcg_pkg::LANE_TWO];
            if (fill_idx == LAST) begin
              primed   <= 1'b1;
              fill_idx <= '0;
            end else begin
              fill_idx <= fill_idx + IW'(1);
            end
          end
          tlcg_pkg::ST_STEP_W: begin
            gen_one   <= r_one;
            gen_two   <= step_r[tlcg_pkg::LANE_TWO];
            gen_three <= step_r[tlcg_pkg::LANE_THREE];
          end
          default: begin
            gen_one <= gen_one;
          end
        endcase
      end
    end
  end

  // Seed is captured with each accepted word.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      seed <= s_tdata[tlcg_pkg::SEED_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {4'b0, rd_data};
    end
  end

`ifndef SYNTHESIS
  // Step results arrive only while the sequencer waits for them.
  a_step_in_wait: assert property (@(posedge clk) disable iff (rst)
    step_valid |-> (state == tlcg_pkg::ST_SEED_W || state == tlcg_pkg::ST_PRE_A_W ||
                    state == tlcg_pkg::ST_PRE_B_W || state == tlcg_pkg::ST_FILL_W ||
                    state == tlcg_pkg::ST_STEP_W))
    else $error("step result outside a wait state");

  // A draw step never starts on an unfilled table.
  a_draw_primed: assert property (@(posedge clk) disable iff (rst)
    (state == tlcg_pkg::ST_STEP) |-> primed)
    else $error("draw started before priming");

  // The selected slot lies inside the table.
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot_valid |-> (slot <= LAST))
    else $error("slot out of range");

  // Generators stay reduced below their moduli.
  a_gen_range: assert property (@(posedge clk) disable iff (rst)
    (gen_one < tlcg_pkg::LCG_M[tlcg_pkg::LANE_ONE]) &&
    (gen_two < tlcg_pkg::LCG_M[tlcg_pkg::LANE_TWO]) &&
    (gen_three < tlcg_pkg::LCG_M[tlcg_pkg::LANE_THREE]))
    else $error("generator out of range");
`endif

endmodule

// ===== hdl/tlcg_step.sv =====
// ============================================================================
// tlcg_step
// Three-lane generator step: x' = (A*x + C) mod M per lane, or for lane one
// in seed mode (C + seed) mod M. Three-stage pipeline with reciprocal
// quotient estimate and a single correcting subtract.
// ============================================================================
module tlcg_step (
  input  logic                           clk,
  input  logic                           rst,
  input  tlcg_pkg::step_req_t            req,
  input  tlcg_pkg::gen_vec_t             x,
  input  logic [tlcg_pkg::SEED_W-1:0]    seed,
  output logic                           out_valid,
  output tlcg_pkg::gen_vec_t             r
);

  logic [2:0] vld;
  logic [tlcg_pkg::LANES-1:0][tlcg_pkg::PW-1:0] p0;
  logic [tlcg_pkg::LANES-1:0][tlcg_pkg::PW-1:0] p1;
  logic [tlcg_pkg::LANES-1:0][tlcg_pkg::QW-1:0] q1;

  // Valid bits travel alongside the data stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], req.valid};
    end
  end

  assign out_valid = vld[2];

  for (genvar l = 0; l < tlcg_pkg::LANES; l++) begin : g_lane
    logic [tlcg_pkg::PW-1:0]             ax;
    logic [tlcg_pkg::PW-1:0]             p_in;
    logic [tlcg_pkg::PW+tlcg_pkg::QW-1:0] prod;
    logic [tlcg_pkg::QW+tlcg_pkg::GW-1:0] qm;
    logic [tlcg_pkg::RW-1:0]             rem;
    logic [tlcg_pkg::RW-1:0]             m_ext;

    // Stage one: linear part, or seed plus increment.
    assign ax = {19'b0, tlcg_pkg::LCG_A[l]} * {14'b0, x[l]};

    always_comb begin
      if (req.seed_mode && (l == tlcg_pkg::LANE_ONE)) begin
        p_in = {16'b0, tlcg_pkg::LCG_C[l]} + {1'b0, seed};
      end else begin
        p_in = ax + {16'b0, tlcg_pkg::LCG_C[l]};
      end
    end

    always_ff @(posedge clk) begin
      p0[l] <= p_in;
    end

    // Stage two: quotient estimate through the reciprocal.
    assign prod = {{tlcg_pkg::QW{1'b0}}, p0[l]}
                * {{tlcg_pkg::PW{1'b0}}, tlcg_pkg::LCG_RECIP[l]};

    always_ff @(posedge clk) begin
      q1[l] <= prod[tlcg_pkg::PW +: tlcg_pkg::QW];
      p1[l] <= p0[l];
    end

    // Stage three: remainder lies below 2M, one subtract corrects it.
    assign qm    = {{tlcg_pkg::GW{1'b0}}, q1[l]}
                 * {{tlcg_pkg::QW{1'b0}}, tlcg_pkg::LCG_M[l]};
    assign rem   = p1[l][tlcg_pkg::RW-1:0] - qm[tlcg_pkg::RW-1:0];
    assign m_ext = {1'b0, tlcg_pkg::LCG_M[l]};

    always_ff @(posedge clk) begin
      if (rem >= m_ext) begin
        r[l] <= tlcg_pkg::GW'(rem - m_ext);
      end else begin
        r[l] <= rem[tlcg_pkg::GW-1:0];
      end
    end
  end

endmodule

// ===== hdl/tlcg_slot.sv =====
// ============================================================================
// tlcg_slot
// Table slot selection: slot = floor(TABLE_SIZE * g3 / M3), computed as a
// three-stage pipeline with a reciprocal estimate and one correction.
// ============================================================================
module tlcg_slot #(
  parameter int TABLE_SIZE = 97
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  tlcg_pkg::gen_t                    g3,
  output logic                              out_valid,
  output logic [$clog2(TABLE_SIZE)-1:0]     slot
);

  localparam int IW = $clog2(TABLE_SIZE);
  localparam int TW = IW + tlcg_pkg::GW;

  logic [2:0]                          vld;
  logic [TW-1:0]                       t0;
  logic [TW-1:0]                       t1;
  logic [IW-1:0]                       qe;
  logic [TW+tlcg_pkg::QW-1:0]          prod;
  logic [IW+tlcg_pkg::GW-1:0]          qm;
  logic [tlcg_pkg::RW-1:0]             rem;

  // Valid bits for the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], in_valid};
    end
  end

  assign out_valid = vld[2];

  // Stage one: scale by the table size.
  always_ff @(posedge clk) begin
    t0 <= TW'(TABLE_SIZE) * {{IW{1'b0}}, g3};
  end

  // Stage two: quotient estimate, low by at most one.
  assign prod = {{tlcg_pkg::QW{1'b0}}, t0}
              * {{TW{1'b0}}, tlcg_pkg::LCG_RECIP[tlcg_pkg::LANE_THREE]};

  always_ff @(posedge clk) begin
    qe <= prod[tlcg_pkg::PW +: IW];
    t1 <= t0;
  end

  // Stage three: bump the quotient when the remainder reaches M3.
  assign qm  = {{tlcg_pkg::GW{1'b0}}, qe}
             * {{IW{1'b0}}, tlcg_pkg::LCG_M[tlcg_pkg::LANE_THREE]};
  assign rem = t1[tlcg_pkg::RW-1:0] - qm[tlcg_pkg::RW-1:0];

  always_ff @(posedge clk) begin
    if (rem >= {1'b0, tlcg_pkg::LCG_M[tlcg_pkg::LANE_THREE]}) begin
      slot <= qe + IW'(1);
    end else begin
      slot <= qe;
    end
  end

endmodule

// ===== hdl/tlcg_table.sv =====
// ============================================================================
// tlcg_table
// Shuffle table storage: one write port and one read port with registered
// read data. Read data holds until the next read.
// ============================================================================
module tlcg_table #(
  parameter int TABLE_SIZE = 97
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(TABLE_SIZE)-1:0]  wr_addr,
  input  logic [tlcg_pkg::NW-1:0]        wr_data,
  input  logic                           rd_en,
  input  logic [$clog2(TABLE_SIZE)-1:0]  rd_addr,
  output logic [tlcg_pkg::NW-1:0]        rd_data
);

  logic [tlcg_pkg::NW-1:0] mem [TABLE_SIZE];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== tb/sv/tb_three_lcg_shuffle_random.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_three_lcg_shuffle_random
// Self-checking bench for the three-generator shuffle random source. Seed and
// reseed words go in on the slave stream. A behavioral copy of the generators
// and the shuffle slots predicts every numerator, and each output word is
// compared in order. A short directed list covers first-draw priming, seed
// extremes and generator wrap points. Random draws with occasional reseeds
// follow, under three idling patterns and one long output stall.
// ============================================================================
module tb_three_lcg_shuffle_random;

  // Generator constants (first-edition three-generator set).
  localparam longint unsigned MOD1 = 259200;
  localparam longint unsigned MUL1 = 7141;
  localparam longint unsigned INC1 = 54773;
  localparam longint unsigned MOD2 = 134456;
  localparam longint unsigned MUL2 = 8121;
  localparam longint unsigned INC2 = 28411;
  localparam longint unsigned MOD3 = 243000;
  localparam longint unsigned MUL3 = 4561;
  localparam longint unsigned INC3 = 51349;
  localparam int              SLOTS = 97;

  localparam bit ACT_DRAW   = 1'b0;
  localparam bit ACT_RESEED = 1'b1;

  localparam int N_RANDOM    = 1350;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 40;

  typedef struct packed {
    logic        action;
    logic [30:0] seed;
  } seed_word_t;

  // Directed words: first draw primes whatever the action says, seed
  // extremes, generator one starting at zero and at M1-1, seed wrapping.
  localparam int N_DIRECTED = 18;
  seed_word_t directed_rows [N_DIRECTED] = '{
    '{ACT_DRAW,   31'd0},
    '{ACT_DRAW,   31'h7FFF_FFFF},
    '{ACT_DRAW,   31'd0},
    '{ACT_RESEED, 31'h7FFF_FFFF},
    '{ACT_DRAW,   31'd0},
    '{ACT_RESEED, 31'd204427},
    '{ACT_DRAW,   31'h7FFF_FFFF},
    '{ACT_RESEED, 31'd204426},
    '{ACT_DRAW,   31'd12345},
    '{ACT_RESEED, 31'd259200},
    '{ACT_RESEED, 31'd0},
    '{ACT_DRAW,   31'd0},
    '{ACT_DRAW,   31'd0},
    '{ACT_RESEED, 31'h5555_5555},
    '{ACT_RESEED, 31'h2AAA_AAAA},
    '{ACT_DRAW,   31'h7FFF_FFFF},
    '{ACT_RESEED, 31'd1},
    '{ACT_RESEED, 31'd1}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [30:0] seed, [31] zero
  logic        s_tuser = 1'b0; // [0] action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [35:0] random_numerator, [39:36] zero

  // Generator state and shuffle slots of the behavioral copy.
  bit [17:0] lcg_one, lcg_two, lcg_three;
  bit [35:0] mix_slots [SLOTS];
  bit        slots_primed;

  bit [35:0] numerator_fifo [$];
  int        mismatch_count = 0;
  int        send_idle_pct  = 0;
  int        recv_idle_pct  = 0;
  int        idle_phase     = 0;

  three_lcg_shuffle_random #(.TABLE_SIZE(SLOTS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // One congruential step; every modulus is below 2^18.
  function automatic bit [17:0] lcg_next(longint unsigned x, longint unsigned mul,
                                         longint unsigned inc, longint unsigned m);
    return 18'((mul * (x % m) + inc) % m);
  endfunction

  function automatic bit [35:0] mix_value();
    return 36'(longint'(lcg_one) * MOD2 + longint'(lcg_two));
  endfunction

  // Priming: generators from the seed, then every slot filled in order.
  function automatic void prime_generators(bit [30:0] seed);
    lcg_one = 18'((INC1 + longint'(seed)) % MOD1);
    lcg_one = lcg_next(lcg_one, MUL1, INC1, MOD1);
    lcg_two = 18'(longint'(lcg_one) % MOD2);
    lcg_one = lcg_next(lcg_one, MUL1, INC1, MOD1);
    lcg_three = 18'(longint'(lcg_one) % MOD3);
    for (int k = 0; k < SLOTS; k++) begin
      lcg_one = lcg_next(lcg_one, MUL1, INC1, MOD1);
      lcg_two = lcg_next(lcg_two, MUL2, INC2, MOD2);
      mix_slots[k] = mix_value();
    end
    slots_primed = 1'b1;
  endfunction

  // One draw: prime if reseeding or unprimed, step all generators, return the picked slot, refill it.
  function automatic bit [35:0] draw_numerator(bit action, bit [30:0] seed);
    longint unsigned slot;
    bit [35:0]       old;
    if (action == ACT_RESEED || !slots_primed) prime_generators(seed);
    lcg_one   = lcg_next(lcg_one, MUL1, INC1, MOD1);
    lcg_two   = lcg_next(lcg_two, MUL2, INC2, MOD2);
    lcg_three = lcg_next(lcg_three, MUL3, INC3, MOD3);
    slot = (SLOTS * longint'(lcg_three)) / MOD3;
    old  = mix_slots[slot];
    mix_slots[slot] = mix_value();
    return old;
  endfunction

  // Offer one word, with random idle cycles ahead of it, and record the
  // expected numerator once it is taken.
  task automatic send_word(bit action, bit [30:0] seed);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= action;
    s_tdata  <= {1'b0, seed};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    numerator_fifo.push_back(draw_numerator(action, seed));
  endtask

  // Output side: random back-pressure and one long hold-off in the last phase.
  initial begin
    int  hold_left;
    bit  held_once;
    bit [35:0] want;
    hold_left = 0;
    held_once = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (idle_phase == 2 && !held_once) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (numerator_fifo.size() == 0) begin
          $display("%0t: unexpected output word %h", $time, m_tdata[35:0]);
          mismatch_count++;
        end else begin
          want = numerator_fifo.pop_front();
          if (m_tdata[35:0] !== want) begin
            $display("%0t: random_numerator expected %h actual %h",
                     $time, want, m_tdata[35:0]);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Main sequence.
  initial begin
    bit        action;
    bit [30:0] seed;
    slots_primed = 1'b0;
    lcg_one = '0;
    lcg_two = '0;
    lcg_three = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 13;
    recv_idle_pct = 62;
    for (int i = 0; i < N_DIRECTED; i++)
      send_word(directed_rows[i].action, directed_rows[i].seed);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) begin
        idle_phase    = 1;
        send_idle_pct = 62;
        recv_idle_pct = 13;
      end else if (i == 2 * N_RANDOM / 3) begin
        idle_phase    = 2;
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Mostly plain draws; reseeds now and then, some near the wrap points.
      action = ($urandom_range(15) == 0) ? ACT_RESEED : ACT_DRAW;
      case ($urandom_range(7))
        0:       seed = 31'($urandom_range(15));
        1:       seed = 31'(204427 - 8 + $urandom_range(16));
        default: seed = 31'($urandom);
      endcase
      send_word(action, seed);
    end
    s_tvalid <= 1'b0;

    while (numerator_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0)
      $display("[three_lcg_shuffle_random] OK");
    else
      $display("[three_lcg_shuffle_random] ERROR");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(12_000_000);
    $display("[three_lcg_shuffle_random] ERROR");
    $finish;
  end

endmodule
